FILE: rtl/core/sde_pkg.sv
// Shared types and constants for the searchable deque engine.
package sde_pkg;

  localparam int DEPTH_DEF       = 64;
  localparam int VALUE_WIDTH_DEF = 16;

  localparam int MODE_W     = 3;
  localparam int VALUE_W    = 16;
  localparam int POSITION_W = 6;
  localparam int DATA_W     = 16;
  localparam int COUNT_W    = 7;

  typedef enum logic [MODE_W-1:0] {
    MODE_APPEND     = 3'd0,
    MODE_POP_FRONT  = 3'd1,
    MODE_POP_BACK   = 3'd2,
    MODE_REMOVE     = 3'd3,
    MODE_CONTAINS   = 3'd4,
    MODE_READ_INDEX = 3'd5,
    MODE_REVERSE    = 3'd6,
    MODE_CLEAR      = 3'd7
  } mode_t;

  typedef struct packed {
    mode_t                 mode;
    logic [VALUE_W-1:0]    value;
    logic [POSITION_W-1:0] position;
  } cmd_t;

  typedef struct packed {
    logic [DATA_W-1:0]  data_out;
    logic               hit;
    logic [COUNT_W-1:0] entry_count;
    logic               is_empty;
    logic               overflow;
  } rsp_t;

endpackage

FILE: rtl/core/sde_ram.sv
// Generic single-write, single-read RAM with registered read data.
module sde_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/core/sde_slot.sv
// Address unit: maps a logical or physical offset to a circular store slot.
module sde_slot #(
  parameter int DEPTH = 64
) (
  input  logic [$clog2(DEPTH)-1:0]   head,
  input  logic [$clog2(DEPTH+1)-1:0] count,
  input  logic                       rev,
  input  logic [$clog2(DEPTH+1)-1:0] idx,
  input  logic                       logical,
  output logic [$clog2(DEPTH)-1:0]   off,
  output logic [$clog2(DEPTH)-1:0]   slot
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [CW-1:0] off_full;
  logic [AW:0]   sum;

  // reversed order: logical index i sits at physical offset count-1-i
  assign off_full = (logical && rev) ? (count - CW'(1) - idx) : idx;
  assign off      = off_full[AW-1:0];
  assign sum      = {1'b0, head} + {1'b0, off};
  assign slot     = (sum >= (AW+1)'(DEPTH)) ? AW'(sum - (AW+1)'(DEPTH)) : sum[AW-1:0];

endmodule

FILE: rtl/core/searchable_deque_engine.sv
// Top level of the searchable deque engine: sequencer, state and result register.
//
// Bounded double-ended list of up to DEPTH values held in a circular RAM
// addressed from a head pointer; a reversed flag flips logical order so a
// reverse request is a single step. A request is taken when start is high
// and busy is low; its result appears on rsp for exactly one cycle with done
// high, and must be captured then, since the receiver cannot stall it.
// From the accepting edge to done: append, reverse, clear, a dropped append,
// a pop on an empty list and an out-of-range read index give done the next
// cycle and never raise busy. Other pops and an in-range read index take one
// RAM read in S_READ. Contains and remove walk the list in logical order, one
// entry per cycle through the single RAM read port and one comparator, until
// a match or, on a miss, the end of the list. Remove then closes the gap in
// physical order in S_SHIFT, one entry moved per cycle. busy is high while a
// request is in S_READ, S_SCAN or S_SHIFT; a new request may start in the
// done cycle.
// No clearing pass is needed after reset: only entries below the fill count
// are ever used.
module searchable_deque_engine #(
  parameter int DEPTH       = sde_pkg::DEPTH_DEF,
  parameter int VALUE_WIDTH = sde_pkg::VALUE_WIDTH_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  sde_pkg::cmd_t cmd,
  output logic          busy,
  output logic          done,
  output sde_pkg::rsp_t rsp
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int PW = (CW > sde_pkg::POSITION_W) ? CW : sde_pkg::POSITION_W;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_READ  = 4'b0010,
    S_SCAN  = 4'b0100,
    S_SHIFT = 4'b1000
  } state_t;

  // sequencer and list state
  state_t                 state, state_next;
  logic [AW-1:0]          head, head_next;
  logic [CW-1:0]          count, count_next;
  logic                   rev, rev_next;
  sde_pkg::mode_t         req_mode, req_mode_next;
  logic [VALUE_WIDTH-1:0] req_val, req_val_next;

  // scan pipeline: si = next logical index to read, c_* = entry being compared
  logic [CW-1:0]          si, si_next;
  logic                   cv, cv_next;
  logic [AW-1:0]          c_off, c_off_next;
  logic [AW-1:0]          c_slot, c_slot_next;

  // gap-closing pipeline: read slot of sk, write arriving data into wslot
  logic [CW-1:0]          sk, sk_next;
  logic                   dv, dv_next;
  logic [AW-1:0]          wslot, wslot_next;
  logic [AW-1:0]          rslot, rslot_next;

  logic                   done_next;
  sde_pkg::rsp_t          rsp_next;

  // address unit
  logic [CW-1:0]          a_idx;
  logic                   a_logical;
  logic [AW-1:0]          a_off;
  logic [AW-1:0]          a_slot;

  // entry RAM
  logic                   ram_we;
  logic [AW-1:0]          ram_waddr;
  logic [VALUE_WIDTH-1:0] ram_wdata;
  logic [VALUE_WIDTH-1:0] ram_rdata;

  logic                   accept;
  logic [VALUE_WIDTH-1:0] val_in;
  logic                   at_head;
  logic                   full;
  logic                   pos_ok;

  // finish bundle
  logic                   fin;
  logic                   fin_hit;
  logic                   fin_ovf;
  logic [VALUE_WIDTH-1:0] fin_data;
  logic [CW-1:0]          fin_count;

  assign busy    = (state != S_IDLE);
  assign accept  = start && !busy;
  assign val_in  = VALUE_WIDTH'(cmd.value);
  assign full    = (count >= CW'(DEPTH));
  assign pos_ok  = (PW'(cmd.position) < PW'(count));
  // the head end is the front in normal order, the back when reversed
  assign at_head = (cmd.mode == sde_pkg::MODE_POP_FRONT) ? !rev : rev;

  sde_slot #(
    .DEPTH (DEPTH)
  ) u_slot (
    .head    (head),
    .count   (count),
    .rev     (rev),
    .idx     (a_idx),
    .logical (a_logical),
    .off     (a_off),
    .slot    (a_slot)
  );

  sde_ram #(
    .WIDTH (VALUE_WIDTH),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (a_slot),
    .rdata (ram_rdata)
  );

  // address unit input select
  always_comb begin
    a_idx     = '0;
    a_logical = 1'b0;
    case (state)
      S_IDLE: begin
        case (cmd.mode)
          sde_pkg::MODE_APPEND: begin
            // reversed append lands one slot before the head
            a_idx = rev ? CW'(DEPTH - 1) : count;
          end
          sde_pkg::MODE_POP_FRONT,
          sde_pkg::MODE_POP_BACK: begin
            a_idx = at_head ? '0 : (count - CW'(1));
          end
          sde_pkg::MODE_READ_INDEX: begin
            a_idx     = CW'(cmd.position);
            a_logical = 1'b1;
          end
          default: begin
            a_idx = '0;
          end
        endcase
      end
      S_SCAN: begin
        a_idx     = si;
        a_logical = 1'b1;
      end
      S_SHIFT: begin
        a_idx = sk;
      end
      default: begin
        a_idx = '0;
      end
    endcase
  end

  // sequencer
  always_comb begin
    state_next    = state;
    head_next     = head;
    count_next    = count;
    rev_next      = rev;
    req_mode_next = req_mode;
    req_val_next  = req_val;
    si_next       = si;
    cv_next       = 1'b0;
    c_off_next    = c_off;
    c_slot_next   = c_slot;
    sk_next       = sk;
    dv_next       = 1'b0;
    wslot_next    = wslot;
    rslot_next    = rslot;
    ram_we        = 1'b0;
    ram_waddr     = wslot;
    ram_wdata     = ram_rdata;
    fin           = 1'b0;
    fin_hit       = 1'b0;
    fin_ovf       = 1'b0;
    fin_data      = '0;
    fin_count     = count;

    case (state)
      S_IDLE: begin
        if (accept) begin
          req_mode_next = cmd.mode;
          req_val_next  = val_in;
          case (cmd.mode)
            sde_pkg::MODE_APPEND: begin
              fin = 1'b1;
              if (full) begin
                fin_ovf = 1'b1;
              end else begin
                ram_we    = 1'b1;
                ram_waddr = a_slot;
                ram_wdata = val_in;
                if (rev) begin
                  head_next = a_slot;
                end
                count_next = count + CW'(1);
                fin_count  = count + CW'(1);
              end
            end
            sde_pkg::MODE_POP_FRONT,
            sde_pkg::MODE_POP_BACK: begin
              if (count == '0) begin
                fin = 1'b1;
              end else begin
                if (at_head) begin
                  head_next = (head == AW'(DEPTH - 1)) ? '0 : (head + AW'(1));
                end
                count_next = count - CW'(1);
                state_next = S_READ;
              end
            end
            sde_pkg::MODE_REMOVE,
            sde_pkg::MODE_CONTAINS: begin
              si_next    = '0;
              state_next = S_SCAN;
            end
            sde_pkg::MODE_READ_INDEX: begin
              if (pos_ok) begin
                state_next = S_READ;
              end else begin
                fin = 1'b1;
              end
            end
            sde_pkg::MODE_REVERSE: begin
              rev_next = !rev;
              fin      = 1'b1;
            end
            sde_pkg::MODE_CLEAR: begin
              count_next = '0;
              head_next  = '0;
              rev_next   = 1'b0;
              fin_count  = '0;
              fin        = 1'b1;
            end
            default: begin
              fin = 1'b1;
            end
          endcase
        end
      end

      S_READ: begin
        fin      = 1'b1;
        fin_hit  = 1'b1;
        fin_data = ram_rdata;
      end

      S_SCAN: begin
        if (cv && (ram_rdata == req_val)) begin
          if (req_mode == sde_pkg::MODE_REMOVE) begin
            sk_next    = CW'(c_off) + CW'(1);
            wslot_next = c_slot;
            state_next = S_SHIFT;
          end else begin
            fin      = 1'b1;
            fin_hit  = 1'b1;
            fin_data = req_val;
          end
        end else if (!cv && (si >= count)) begin
          fin = 1'b1;
        end else if (si < count) begin
          cv_next     = 1'b1;
          c_off_next  = a_off;
          c_slot_next = a_slot;
          si_next     = si + CW'(1);
        end
      end

      S_SHIFT: begin
        if (!dv && (sk >= count)) begin
          count_next = count - CW'(1);
          fin        = 1'b1;
          fin_hit    = 1'b1;
          fin_data   = req_val;
          fin_count  = count - CW'(1);
        end else begin
          if (dv) begin
            ram_we     = 1'b1;
            ram_waddr  = wslot;
            ram_wdata  = ram_rdata;
            wslot_next = rslot;
          end
          if (sk < count) begin
            rslot_next = a_slot;
            dv_next    = 1'b1;
            sk_next    = sk + CW'(1);
          end
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase

    if (fin) begin
      state_next = S_IDLE;
    end

    done_next            = fin;
    rsp_next.data_out    = sde_pkg::DATA_W'(fin_data);
    rsp_next.hit         = fin_hit;
    rsp_next.entry_count = sde_pkg::COUNT_W'(fin_count);
    rsp_next.is_empty    = (fin_count == '0);
    rsp_next.overflow    = fin_ovf;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      head  <= '0;
      count <= '0;
      rev   <= 1'b0;
      cv    <= 1'b0;
      dv    <= 1'b0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      head  <= head_next;
      count <= count_next;
      rev   <= rev_next;
      cv    <= cv_next;
      dv    <= dv_next;
      done  <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    req_mode <= req_mode_next;
    req_val  <= req_val_next;
    si       <= si_next;
    c_off    <= c_off_next;
    c_slot   <= c_slot_next;
    sk       <= sk_next;
    wslot    <= wslot_next;
    rslot    <= rslot_next;
    if (fin) begin
      rsp <= rsp_next;
    end
  end

  // a result only follows an accepted request or work in progress
  a_done_source: assert property (@(posedge clk) disable iff (rst)
    done |-> ($past(state != S_IDLE) || $past(start)))
    else $error("done without a request");

  // the list length is frozen while the search walks it
  a_scan_count: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |=> (count == $past(count)))
    else $error("count changed during scan");

  // overflow is reported only when the list was full
  a_ovf_full: assert property (@(posedge clk) disable iff (rst)
    (done && rsp.overflow) |-> ($past(count) == CW'(DEPTH)))
    else $error("overflow with room left");

  // the RAM is written only by an append or by the gap-closing pass
  a_write_state: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> ((state == S_IDLE) || (state == S_SHIFT)))
    else $error("RAM write outside append or shift");

  // a miss always reports zero data
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    (done && !rsp.hit) |-> (rsp.data_out == '0))
    else $error("nonzero data on a miss");

endmodule
